// ===== hdl/assert_macros.svh =====
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same, with no reset qualifier
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hdl/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// drc_pkg
// types and codes shared by the dirty rectangle coalescer
// ----------------------------------------------------------------------------
`default_nettype none
package drc_pkg;
    typedef struct packed {
        logic [7:0] h;
        logic [7:0] w;
        logic [7:0] y;
        logic [7:0] x;
    } t_rect;

    localparam logic [1:0] ST_DROPPED = 2'd0;
    localparam logic [1:0] ST_QUEUED  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REMOVE,
        S_DONE
    } t_state;

    // shift command broadcast along the cell row
    typedef struct packed {
        logic rotate;   // shift toward head, head wraps to the last live slot
        logic pop;      // shift toward head, head is dropped
    } t_cell_ctl;

    // point inside a box, inclusive bounds
    function automatic logic pt_in_rect(input logic [7:0] px, input logic [7:0] py,
                                        input logic [7:0] x1, input logic [7:0] y1,
                                        input logic [7:0] x2, input logic [7:0] y2);
        return (x1 <= px) && (x2 >= px) && (y1 <= py) && (y2 >= py);
    endfunction
endpackage
`default_nettype wire

// ===== hdl/drc_cell.sv =====
// ----------------------------------------------------------------------------
// drc_cell
// one queue slot; shifts its entry toward the head on command
// ----------------------------------------------------------------------------
`default_nettype none
module drc_cell (
    input  wire logic              i_clk,
    input  wire drc_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_load_here,
    input  wire drc_pkg::t_rect    i_load_rect,
    input  wire drc_pkg::t_rect    i_next,
    output drc_pkg::t_rect         o_rect
);
    import drc_pkg::*;

    t_rect r_rect;
    t_rect n_rect;

    always_comb begin
        n_rect = r_rect;
        if (i_load_here) begin
            n_rect = i_load_rect;
        end else if (i_ctl.rotate || i_ctl.pop) begin
            n_rect = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rect <= n_rect;
    end

    assign o_rect = r_rect;
endmodule
`default_nettype wire

// ===== hdl/dirty_rect_coalescer.sv =====
// ----------------------------------------------------------------------------
// dirty_rect_coalescer
// queue of dirty rectangles with merge on add, held in a row of shift cells
// ----------------------------------------------------------------------------
// a take, or an add dropped on a pending full update, goes from S_IDLE through
//   S_DONE to the o_valid strobe; other adds alternate scan passes (S_SCAN)
//   with removals of the absorbed entry (S_REMOVE) until a pass absorbs
//   nothing, then go through S_DONE to the strobe
// throughput: one item at a time, busy stays high through the strobe cycle,
//   so the next transfer can be accepted in the cycle after the result; no stalls
// reset (synchronous, active low) empties the queue and clears full mode
`default_nettype none
module dirty_rect_coalescer #(
    parameter int MAX_UPDATES = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       i_operation,
    input  wire logic [7:0] i_area_x,
    input  wire logic [7:0] i_area_y,
    input  wire logic [7:0] i_area_w,
    input  wire logic [7:0] i_area_h,
    output logic            o_valid,
    output logic [1:0]      o_add_status,
    output logic [3:0]      o_merge_count,
    output logic            o_take_valid,
    output logic            o_take_full,
    output logic [7:0]      o_out_x,
    output logic [7:0]      o_out_y,
    output logic [7:0]      o_out_w,
    output logic [7:0]      o_out_h
);
    import drc_pkg::*;

    localparam int LW = $clog2(MAX_UPDATES + 1);
    localparam int IW = (MAX_UPDATES > 1) ? $clog2(MAX_UPDATES) : 1;

    // control state
    t_state          r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic            r_full, n_full;
    logic [LW-1:0]   r_pos, n_pos;     // entries examined in this pass / removal
    logic [IW-1:0]   r_tidx, n_tidx;   // slot of the first touching entry
    logic            r_hit, n_hit;     // touching entry found in this pass
    logic            r_eq, n_eq;       // equal entry found in this pass
    logic [3:0]      r_merges, n_merges;
    t_rect           r_cur, n_cur;     // rectangle being added
    t_rect           r_mrg, n_mrg;     // bounding box with the touching entry

    // result registers
    logic            r_valid;
    logic [1:0]      r_status, n_status;
    logic            r_tvalid, n_tvalid, r_tfull, n_tfull;
    t_rect           r_orect, n_orect;

    // cell row
    t_rect           w_cell [MAX_UPDATES];
    t_cell_ctl       w_ctl;
    logic            w_load_en;
    logic [LW-1:0]   w_load_pos;
    t_rect           w_load_rect;

    // handshake and sequencing helpers
    logic            w_accept;
    logic            w_pass_end;
    logic            w_rm_here;
    logic            w_rm_done;

    // head compare
    t_rect      w_head;
    logic [7:0] w_x2, w_y2, w_qx2, w_qy2;
    logic       w_touch, w_equal;
    logic [7:0] w_mx, w_my, w_mx2, w_my2;

    // rotation runs over the live part only: the head wraps into slot len-1,
    // so after len rotations the queue is back in order; slots past the
    // live part shift along and hold nothing of value
    for (genvar g = 0; g < MAX_UPDATES; g++) begin : g_cell
        t_rect w_next;
        logic  w_load_here;
        if (g == MAX_UPDATES - 1) begin : g_last
            assign w_next = w_cell[0];
        end else begin : g_mid
            assign w_next = (w_ctl.rotate && r_len == LW'(g + 1)) ? w_cell[0] : w_cell[g+1];
        end
        assign w_load_here = w_load_en && (w_load_pos == LW'(g));
        drc_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_load_here(w_load_here),
            .i_load_rect(w_load_rect),
            .i_next     (w_next),
            .o_rect     (w_cell[g])
        );
    end

    assign w_head = w_cell[0];
    // right and bottom edges wrap at 8 bits
    assign w_x2   = r_cur.x + r_cur.w;
    assign w_y2   = r_cur.y + r_cur.h;
    assign w_qx2  = w_head.x + w_head.w;
    assign w_qy2  = w_head.y + w_head.h;
    assign w_equal = (w_head == r_cur);
    // a corner of either rectangle inside the other
    assign w_touch =
        pt_in_rect(r_cur.x, r_cur.y, w_head.x, w_head.y, w_qx2, w_qy2) ||
        pt_in_rect(r_cur.x, w_y2,    w_head.x, w_head.y, w_qx2, w_qy2) ||
        pt_in_rect(w_x2,    w_y2,    w_head.x, w_head.y, w_qx2, w_qy2) ||
        pt_in_rect(w_x2,    r_cur.y, w_head.x, w_head.y, w_qx2, w_qy2) ||
        pt_in_rect(w_head.x, w_head.y, r_cur.x, r_cur.y, w_x2, w_y2) ||
        pt_in_rect(w_head.x, w_qy2,    r_cur.x, r_cur.y, w_x2, w_y2) ||
        pt_in_rect(w_qx2,    w_qy2,    r_cur.x, r_cur.y, w_x2, w_y2) ||
        pt_in_rect(w_qx2,    w_head.y, r_cur.x, r_cur.y, w_x2, w_y2);
    assign w_mx  = (w_head.x < r_cur.x) ? w_head.x : r_cur.x;
    assign w_my  = (w_head.y < r_cur.y) ? w_head.y : r_cur.y;
    assign w_mx2 = (w_qx2 > w_x2) ? w_qx2 : w_x2;
    assign w_my2 = (w_qy2 > w_y2) ? w_qy2 : w_y2;

    assign w_accept   = start && !busy;
    // a pass is over once every live entry has been seen at the head
    assign w_pass_end = (r_pos == r_len);
    // removal: rotate the target to the head, pop it, rotate the rest home
    assign w_rm_here  = (r_pos == LW'(r_tidx));
    assign w_rm_done  = w_rm_here ? (LW'(r_tidx) + LW'(1) == r_len) : (r_pos == r_len);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_operation == OP_TAKE || (r_full && r_len != '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_pass_end) begin
                    if (!r_eq && r_hit) begin
                        n_state = S_REMOVE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_REMOVE: begin
                if (w_rm_done) begin
                    n_state = S_SCAN;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and cell row control
    always_comb begin
        n_len       = r_len;
        n_full      = r_full;
        n_pos       = r_pos;
        n_tidx      = r_tidx;
        n_hit       = r_hit;
        n_eq        = r_eq;
        n_merges    = r_merges;
        n_cur       = r_cur;
        n_mrg       = r_mrg;
        n_status    = r_status;
        n_tvalid    = r_tvalid;
        n_tfull     = r_tfull;
        n_orect     = r_orect;
        w_ctl       = '0;
        w_load_en   = 1'b0;
        w_load_pos  = r_len;
        w_load_rect = r_cur;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cur    = '{h: i_area_h, w: i_area_w, y: i_area_y, x: i_area_x};
                    n_merges = '0;
                    n_pos    = '0;
                    n_hit    = 1'b0;
                    n_eq     = 1'b0;
                    n_status = ST_DROPPED;
                    n_tvalid = 1'b0;
                    n_tfull  = 1'b0;
                    n_orect  = '0;
                    if (i_operation == OP_TAKE && r_len != '0) begin
                        n_tvalid = 1'b1;
                        if (r_full) begin
                            // full update leaves no rectangle to report
                            n_tfull = 1'b1;
                            n_full  = 1'b0;
                            n_len   = '0;
                        end else begin
                            n_orect   = w_head;
                            n_len     = r_len - LW'(1);
                            w_ctl.pop = 1'b1;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_pass_end) begin
                    n_pos = '0;
                    if (!r_eq && !r_hit) begin
                        if (r_len >= LW'(MAX_UPDATES)) begin
                            // overflow: the whole queue becomes one full update
                            n_len       = LW'(1);
                            n_full      = 1'b1;
                            w_load_en   = 1'b1;
                            w_load_pos  = '0;
                            w_load_rect = '0;
                            n_status    = ST_FULL;
                        end else begin
                            w_load_en = 1'b1;
                            n_len     = r_len + LW'(1);
                            n_status  = ST_QUEUED;
                        end
                    end
                end else begin
                    w_ctl.rotate = 1'b1;
                    n_pos        = r_pos + LW'(1);
                    if (w_equal) begin
                        n_eq = 1'b1;
                    end
                    // only the first touching entry of a pass is absorbed
                    if (w_touch && !r_hit) begin
                        n_hit  = 1'b1;
                        n_tidx = r_pos[IW-1:0];
                        n_mrg  = '{h: w_my2 - w_my, w: w_mx2 - w_mx, y: w_my, x: w_mx};
                    end
                end
            end
            S_REMOVE: begin
                if (w_rm_here) begin
                    w_ctl.pop = 1'b1;
                    n_len     = r_len - LW'(1);
                end else begin
                    w_ctl.rotate = 1'b1;
                end
                if (w_rm_done) begin
                    // restart the scan with the grown rectangle
                    n_pos = '0;
                    n_hit = 1'b0;
                    n_eq  = 1'b0;
                    n_cur = r_mrg;
                    if (r_merges != 4'hF) begin
                        n_merges = r_merges + 4'd1;
                    end
                end else begin
                    n_pos = r_pos + LW'(1);
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_full   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_full   <= n_full;
            r_valid  <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_tidx   <= n_tidx;
        r_hit    <= n_hit;
        r_eq     <= n_eq;
        r_merges <= n_merges;
        r_cur    <= n_cur;
        r_mrg    <= n_mrg;
        r_status <= n_status;
        r_tvalid <= n_tvalid;
        r_tfull  <= n_tfull;
        r_orect  <= n_orect;
    end

    assign busy          = (r_state != S_IDLE) || r_valid;
    assign o_valid       = r_valid;
    assign o_add_status  = r_status;
    assign o_merge_count = r_merges;
    assign o_take_valid  = r_tvalid;
    assign o_take_full   = r_tfull;
    assign o_out_x       = r_orect.x;
    assign o_out_y       = r_orect.y;
    assign o_out_w       = r_orect.w;
    assign o_out_h       = r_orect.h;
endmodule
`default_nettype wire

// ===== hdl/drc_checker.sv =====
// ----------------------------------------------------------------------------
// drc_checker
// port-level checks on the coalescer command interface
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module drc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic [1:0] o_add_status,
    input wire logic       o_take_valid,
    input wire logic       o_take_full
);
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "no busy after accept")
    `ASSERT_CLK(a_valid_pulse, i_clk, i_rst_n, o_valid |=> !o_valid, "result strobe too long")
    `ASSERT_CLK(a_full_take, i_clk, i_rst_n, (o_valid && o_take_full) |-> o_take_valid, "full without take")
    `ASSERT_CLK(a_take_status, i_clk, i_rst_n, (o_valid && o_take_valid) |-> (o_add_status == 2'd0), "status on take")
endmodule

bind dirty_rect_coalescer drc_checker u_drc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_add_status (o_add_status),
    .o_take_valid (o_take_valid),
    .o_take_full  (o_take_full)
);
`default_nettype wire

// ===== tb/tb_dirty_rect_coalescer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dirty_rect_coalescer
// self-checking bench: random and directed add/take transfers, each result
// compared field by field against a behavioral merge queue kept in the bench
// ----------------------------------------------------------------------------
`default_nettype none
module tb_dirty_rect_coalescer;
    import drc_pkg::*;

    localparam int QDEPTH    = 8;
    localparam int WD_LIMIT  = 4000;
    localparam int N_RANDOM  = 1400;

    typedef struct packed {
        logic       op;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] merges;
        logic       tvalid;
        logic       tfull;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_operation;
    logic [7:0] i_area_x, i_area_y, i_area_w, i_area_h;
    logic o_valid;
    logic [1:0] o_add_status;
    logic [3:0] o_merge_count;
    logic o_take_valid, o_take_full;
    logic [7:0] o_out_x, o_out_y, o_out_w, o_out_h;

    dirty_rect_coalescer #(.MAX_UPDATES(QDEPTH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_area_x(i_area_x), .i_area_y(i_area_y),
        .i_area_w(i_area_w), .i_area_h(i_area_h), .o_valid(o_valid),
        .o_add_status(o_add_status), .o_merge_count(o_merge_count),
        .o_take_valid(o_take_valid), .o_take_full(o_take_full),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_w(o_out_w), .o_out_h(o_out_h)
    );

    // clock, 4 ns period
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the rectangle queue
    t_rect   shadow_rects[QDEPTH];
    int      shadow_len;
    bit      shadow_full;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      errors;
    int      idle_pct;
    int      watchdog;

    function automatic bit touches(t_rect a, t_rect b);
        logic [7:0] ax2, ay2, bx2, by2;
        ax2 = a.x + a.w;
        ay2 = a.y + a.h;
        bx2 = b.x + b.w;
        by2 = b.y + b.h;
        return pt_in_rect(a.x, a.y, b.x, b.y, bx2, by2) ||
               pt_in_rect(a.x, ay2, b.x, b.y, bx2, by2) ||
               pt_in_rect(ax2, ay2, b.x, b.y, bx2, by2) ||
               pt_in_rect(ax2, a.y, b.x, b.y, bx2, by2) ||
               pt_in_rect(b.x, b.y, a.x, a.y, ax2, ay2) ||
               pt_in_rect(b.x, by2, a.x, a.y, ax2, ay2) ||
               pt_in_rect(bx2, by2, a.x, a.y, ax2, ay2) ||
               pt_in_rect(bx2, b.y, a.x, a.y, ax2, ay2);
    endfunction

    function automatic void drop_rect(int idx);
        for (int i = idx; i < shadow_len - 1; i++)
            shadow_rects[i] = shadow_rects[i + 1];
        if (shadow_len > 0)
            shadow_len--;
    endfunction

    // apply one transfer to the shadow queue and return the expected result
    function automatic t_result coalesce(t_item it);
        t_result r;
        t_rect   cur, q;
        int      merges;
        bit      merged, dup;
        logic [7:0] qx2, qy2, cx2, cy2;
        r = '0;
        if (it.op == OP_TAKE) begin
            if (shadow_len == 0)
                return r;
            r.tvalid = 1'b1;
            if (shadow_full) begin
                r.tfull = 1'b1;
                shadow_full = 1'b0;
                shadow_len = 0;
                return r;
            end
            r.x = shadow_rects[0].x;
            r.y = shadow_rects[0].y;
            r.w = shadow_rects[0].w;
            r.h = shadow_rects[0].h;
            drop_rect(0);
            return r;
        end
        r.status = ST_DROPPED;
        if (shadow_full && shadow_len > 0)
            return r;
        cur = '{h: it.h, w: it.w, y: it.y, x: it.x};
        merges = 0;
        do begin
            merged = 1'b0;
            dup = 1'b0;
            for (int i = 0; i < shadow_len; i++)
                if (shadow_rects[i] == cur)
                    dup = 1'b1;
            if (dup) begin
                r.merges = (merges > 15) ? 4'd15 : 4'(merges);
                return r;
            end
            for (int i = 0; i < shadow_len && !merged; i++) begin
                q = shadow_rects[i];
                if (touches(cur, q)) begin
                    drop_rect(i);
                    merges++;
                    qx2 = q.x + q.w;
                    qy2 = q.y + q.h;
                    cx2 = cur.x + cur.w;
                    cy2 = cur.y + cur.h;
                    if (q.x < cur.x) cur.x = q.x;
                    if (q.y < cur.y) cur.y = q.y;
                    if (cx2 > qx2) qx2 = cx2;
                    if (cy2 > qy2) qy2 = cy2;
                    cur.w = qx2 - cur.x;
                    cur.h = qy2 - cur.y;
                    merged = 1'b1;
                end
            end
        end while (merged);
        r.merges = (merges > 15) ? 4'd15 : 4'(merges);
        if (shadow_len >= QDEPTH) begin
            shadow_len = 1;
            shadow_full = 1'b1;
            shadow_rects[0] = '0;
            r.status = ST_FULL;
            return r;
        end
        shadow_rects[shadow_len] = cur;
        shadow_len++;
        r.status = ST_QUEUED;
        return r;
    endfunction

    // driver: holds start while an item waits, predicts at the accepting edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(coalesce(pending_items.pop_front()));
            end
            if (start && busy) begin
                // transfer still pending, keep everything stable
            end else if (pending_items.size() > 0 && ($urandom_range(99) >= idle_pct)) begin
                start       <= 1'b1;
                i_operation <= pending_items[0].op;
                i_area_x    <= pending_items[0].x;
                i_area_y    <= pending_items[0].y;
                i_area_w    <= pending_items[0].w;
                i_area_h    <= pending_items[0].h;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: each strobe is compared with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r, act;
        if (i_rst_n && o_valid) begin
            act = '{status: o_add_status, merges: o_merge_count, tvalid: o_take_valid,
                    tfull: o_take_full, x: o_out_x, y: o_out_y, w: o_out_w, h: o_out_h};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, act);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (act !== exp_r) begin
                    $display("%0t: mismatch expected status=%0d merges=%0d tv=%0b tf=%0b %h_%h_%h_%h",
                             $time, exp_r.status, exp_r.merges, exp_r.tvalid, exp_r.tfull,
                             exp_r.x, exp_r.y, exp_r.w, exp_r.h);
                    $display("%0t:          actual   status=%0d merges=%0d tv=%0b tf=%0b %h_%h_%h_%h",
                             $time, act.status, act.merges, act.tvalid, act.tfull,
                             act.x, act.y, act.w, act.h);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            watchdog <= 0;
        end else if (pending_items.size() > 0 || expected_results.size() > 0) begin
            watchdog <= watchdog + 1;
            if (watchdog >= WD_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic t_item add_item(logic [7:0] x, logic [7:0] y,
                                       logic [7:0] w, logic [7:0] h);
        t_item it;
        it = '{op: OP_ADD, x: x, y: y, w: w, h: h};
        return it;
    endfunction

    function automatic t_item take_item();
        t_item it;
        it = '0;
        it.op = OP_TAKE;
        it.x = 8'($urandom);
        it.y = 8'($urandom);
        it.w = 8'($urandom);
        it.h = 8'($urandom);
        return it;
    endfunction

    // mostly clustered small rectangles so merges and overflow both happen
    function automatic t_item random_item();
        int k;
        k = $urandom_range(99);
        if (k < 30)
            return take_item();
        if (k < 80)
            return add_item(8'($urandom_range(63)), 8'($urandom_range(63)),
                            8'($urandom_range(7)), 8'($urandom_range(7)));
        if (k < 90)
            return add_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(3)), 8'($urandom_range(3)));
        return add_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        errors = 0;
        idle_pct = 32;
        start = 1'b0;
        i_operation = OP_ADD;
        i_area_x = '0;
        i_area_y = '0;
        i_area_w = '0;
        i_area_h = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty take, extremes, duplicate, wrap, merge chain, overflow
        pending_items.push_back(take_item());
        pending_items.push_back(add_item(8'd0, 8'd0, 8'd0, 8'd0));
        pending_items.push_back(add_item(8'd0, 8'd0, 8'd0, 8'd0));
        pending_items.push_back(add_item(8'd255, 8'd255, 8'd255, 8'd255));
        pending_items.push_back(add_item(8'd250, 8'd10, 8'd20, 8'd3));
        pending_items.push_back(add_item(8'd100, 8'd100, 8'd2, 8'd2));
        pending_items.push_back(add_item(8'd102, 8'd102, 8'd2, 8'd2));
        pending_items.push_back(take_item());
        pending_items.push_back(take_item());
        pending_items.push_back(take_item());
        pending_items.push_back(take_item());
        pending_items.push_back(take_item());
        // chain: two separate rects then one bridging both; then its duplicate
        pending_items.push_back(add_item(8'd10, 8'd10, 8'd1, 8'd1));
        pending_items.push_back(add_item(8'd20, 8'd10, 8'd1, 8'd1));
        pending_items.push_back(add_item(8'd11, 8'd10, 8'd9, 8'd0));
        pending_items.push_back(add_item(8'd10, 8'd10, 8'd11, 8'd1));
        // fill past capacity with disjoint rects
        for (int i = 0; i < 9; i++)
            pending_items.push_back(add_item(8'(40 + 20 * i), 8'd200, 8'd1, 8'd1));
        pending_items.push_back(add_item(8'd0, 8'd0, 8'd1, 8'd1));
        pending_items.push_back(take_item());
        pending_items.push_back(take_item());
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                wait_drained();
                idle_pct = 77;
            end else if (i == 2 * N_RANDOM / 3) begin
                wait_drained();
                idle_pct = 0;
            end
            pending_items.push_back(random_item());
        end
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
